@@ rtl/dwrg_pkg.sv @@
`default_nettype none
package dwrg_pkg;

    localparam int LVL_W = 24;
    localparam int PIX_W = 3 * LVL_W;
    localparam int TAP_W = 4;

    typedef logic signed [LVL_W-1:0] t_lvl;
    typedef logic [PIX_W-1:0]        t_pix;
    typedef logic [TAP_W-1:0]        t_tap;

    // 3x3 neighborhood, center tap last
    localparam t_tap TAP_CENTER = 4'd8;

    localparam t_lvl Q_MAX    = 24'sd8388607;
    localparam t_lvl Q_MIN    = -24'sd8388608;
    localparam t_lvl DROP_RAW = 24'sd1048320;

    // normalized inverse-square weights, Q0.16
    localparam logic [15:0] W_EDGE = 16'd10923;
    localparam logic [15:0] W_DIAG = 16'd5461;

    localparam logic [15:0] SPRING [3] = '{16'd6619, 16'd6554, 16'd6488};
    localparam logic [15:0] DAMP       = 16'd131;

    localparam logic CFG_DESIRED = 1'b0;
    localparam logic CFG_GAP     = 1'b1;

    typedef struct packed {
        logic accept;
        logic clr;
        logic tap_issue;
        t_tap tap;
        logic rd_pix;
        logic calc1;
        logic calc2;
        logic calc3;
        logic wr;
        logic fin;
        logic out_rd;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic signed [1:0] tap_dx(input t_tap t);
        logic signed [1:0] r;
        case (t)
            4'd0, 4'd3, 4'd5: r = -2'sd1;
            4'd2, 4'd4, 4'd7: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] tap_dy(input t_tap t);
        logic signed [1:0] r;
        case (t)
            4'd0, 4'd1, 4'd2: r = -2'sd1;
            4'd5, 4'd6, 4'd7: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] tap_weight(input t_tap t);
        return (tap_dx(t) != 2'sd0 && tap_dy(t) != 2'sd0) ? W_DIAG : W_EDGE;
    endfunction

    function automatic t_lvl sat24(input logic signed [33:0] v);
        t_lvl r;
        if (v > 34'(Q_MAX))      r = Q_MAX;
        else if (v < 34'(Q_MIN)) r = Q_MIN;
        else                     r = v[LVL_W-1:0];
        return r;
    endfunction

    function automatic logic [7:0] led_clamp(input t_lvl v);
        logic [7:0] r;
        if (v < 24'sd0)           r = 8'd0;
        else if (v > 24'sd65280)  r = 8'd255;
        else                      r = v[15:8];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/damped_wave_ripple_grid.sv @@
// an advance makes nine level-memory reads per pixel through one read port, drains, then
//   runs the update (C1, C2, C3, write); a read passes through RD1 and RD2
// throughput: one word at a time; the next word is taken while a result waits
// reset: synchronous, active low; a clearing pass over every pixel
//   zeroes bank-0 levels and velocities before the first word is taken
`default_nettype none
module damped_wave_ripple_grid #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_now_seconds,
    input  wire logic [2:0]  i_drop_x,
    input  wire logic [2:0]  i_drop_y,
    input  wire logic [2:0]  i_read_x,
    input  wire logic [2:0]  i_read_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red_byte,
    output logic [7:0]       o_green_byte,
    output logic [7:0]       o_blue_byte,
    output logic [15:0]      o_level_total,
    output logic             o_drop_made
);
    import dwrg_pkg::*;

    t_cmd  cmd;
    t_stat st;
    logic [$clog2(GRID_WIDTH)-1:0]  x;
    logic [$clog2(GRID_HEIGHT)-1:0] y;

    dwrg_ctrl #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_action(i_action),
        .o_ready(o_ready), .i_st(st), .o_cmd(cmd), .o_x(x), .o_y(y)
    );

    dwrg_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_st(st), .i_x(x), .i_y(y),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_action(i_action), .i_now_seconds(i_now_seconds),
        .i_drop_x(i_drop_x), .i_drop_y(i_drop_y),
        .i_read_x(i_read_x), .i_read_y(i_read_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_red_byte(o_red_byte), .o_green_byte(o_green_byte),
        .o_blue_byte(o_blue_byte), .o_level_total(o_level_total),
        .o_drop_made(o_drop_made)
    );
endmodule
`default_nettype wire

@@ rtl/dwrg_ram.sv @@
`default_nettype none
module dwrg_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/dwrg_ctrl.sv @@
`default_nettype none
module dwrg_ctrl #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           i_action,
    output logic                                o_ready,
    input  wire dwrg_pkg::t_stat                i_st,
    output dwrg_pkg::t_cmd                      o_cmd,
    output logic [$clog2(GRID_WIDTH)-1:0]       o_x,
    output logic [$clog2(GRID_HEIGHT)-1:0]      o_y
);
    import dwrg_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TAP   = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_C1    = 4'd4;
    localparam logic [3:0] S_C2    = 4'd5;
    localparam logic [3:0] S_C3    = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_RD1   = 4'd9;
    localparam logic [3:0] S_RD2   = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    t_tap          r_t, n_t;
    logic          r_w, n_w;
    logic          accept, last_pix;

    assign accept   = i_valid && o_ready;
    assign last_pix = (r_x == X_LAST) && (r_y == Y_LAST);
    assign o_ready  = (r_state == S_IDLE);
    assign o_x      = r_x;
    assign o_y      = r_y;

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_t     = r_t;
        n_w     = r_w;
        o_cmd   = '0;
        o_cmd.accept = accept;
        o_cmd.tap    = r_t;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_x == X_LAST) begin
                    n_x = '0;
                    n_y = r_y + 1'b1;
                end else begin
                    n_x = r_x + 1'b1;
                end
                if (last_pix) begin
                    n_y     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_x = '0;
                    n_y = '0;
                    n_t = '0;
                    n_state = i_action ? S_RD1 : S_TAP;
                end
            end
            S_TAP: begin
                o_cmd.tap_issue = 1'b1;
                n_t = r_t + 1'b1;
                if (r_t == TAP_CENTER) begin
                    n_w     = 1'b0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // product and accumulate stages drain
                n_w = 1'b1;
                if (r_w) n_state = S_C1;
            end
            S_C1: begin
                o_cmd.calc1 = 1'b1;
                n_state = S_C2;
            end
            S_C2: begin
                o_cmd.calc2 = 1'b1;
                n_state = S_C3;
            end
            S_C3: begin
                o_cmd.calc3 = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_t = '0;
                if (r_x == X_LAST) begin
                    n_x = '0;
                    n_y = r_y + 1'b1;
                end else begin
                    n_x = r_x + 1'b1;
                end
                if (last_pix) begin
                    n_y     = '0;
                    n_state = S_FIN;
                end else begin
                    n_state = S_TAP;
                end
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD1: begin
                o_cmd.rd_pix = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_pix = 1'b1;
                if (i_st.out_free) begin
                    o_cmd.out_rd = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_x     <= '0;
            r_y     <= '0;
            r_t     <= '0;
            r_w     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_t     <= n_t;
            r_w     <= n_w;
        end
    end

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_t <= TAP_CENTER))
        else $error("tap index past center");
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && last_pix) |=> (r_state == S_FIN))
        else $error("frame did not finish after last pixel");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && i_st.out_free) |=> (r_state == S_IDLE && r_x == '0))
        else $error("finish did not return to idle");
endmodule
`default_nettype wire

@@ rtl/dwrg_dp.sv @@
`default_nettype none
module dwrg_dp #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dwrg_pkg::t_cmd                 i_cmd,
    output dwrg_pkg::t_stat                     o_st,
    input  wire logic [$clog2(GRID_WIDTH)-1:0]  i_x,
    input  wire logic [$clog2(GRID_HEIGHT)-1:0] i_y,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_action,
    input  wire logic [31:0]                    i_now_seconds,
    input  wire logic [2:0]                     i_drop_x,
    input  wire logic [2:0]                     i_drop_y,
    input  wire logic [2:0]                     i_read_x,
    input  wire logic [2:0]                     i_read_y,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [7:0]                          o_red_byte,
    output logic [7:0]                          o_green_byte,
    output logic [7:0]                          o_blue_byte,
    output logic [15:0]                         o_level_total,
    output logic                                o_drop_made
);
    import dwrg_pkg::*;

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int NPIX  = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(NPIX);
    localparam int NCELL = NPIX * 3;
    localparam int TOT_W = $clog2(NCELL * 255 + 1);

    typedef logic [AW-1:0] t_addr;

    // configuration and frame state
    logic [7:0]       r_desired, r_gap;
    logic [31:0]      r_last;
    logic [TOT_W-1:0] r_byte_total, r_tot;
    logic             r_bank, r_drop_on;
    t_addr            r_drop_addr;
    logic [2:0]       r_rx, r_ry;

    // memories
    t_pix  rd0, rd1, lvl_rd;
    t_pix  vel_rd;
    t_addr pix_addr, tap_addr, read_addr, lvl_raddr;
    t_pix  next_word;
    logic  we0, we1, vwe;

    // tap pipeline
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic        tap_in, tap_is_drop;
    logic        r_m_v, r_m_c, r_m_d;
    logic [15:0] r_m_w;
    logic        r_pv;
    logic signed [40:0] r_prod [3];
    logic signed [43:0] r_acc  [3];
    t_lvl               r_lvl  [3];
    logic signed [28:0] r_diff [3];
    logic signed [32:0] r_dprod[3];
    logic signed [45:0] r_aprod[3];
    t_lvl               r_nv   [3];
    t_lvl               nxt    [3];
    logic [7:0]         nbyte  [3];
    logic [7:0]         rbyte  [3];
    logic               read_in;
    logic               drop_ok;
    logic [2:0]         dx_m, dy_m;

    function automatic logic [2:0] wrap(input logic [2:0] v, input int lim);
        logic [2:0] r;
        r = v;
        for (int k = 0; k < 4; k++) begin
            if (32'(r) >= 32'(lim)) r = 3'(32'(r) - 32'(lim));
        end
        return r;
    endfunction

    assign pix_addr  = AW'(32'(i_y) * 32'(GRID_WIDTH) + 32'(i_x));
    assign nx        = $signed({2'b00, i_x}) + (XW+2)'(tap_dx(i_cmd.tap));
    assign ny        = $signed({2'b00, i_y}) + (YW+2)'(tap_dy(i_cmd.tap));
    assign tap_in    = (nx >= 0) && (nx < $signed((XW+2)'(GRID_WIDTH)))
                    && (ny >= 0) && (ny < $signed((YW+2)'(GRID_HEIGHT)));
    assign tap_addr  = AW'(32'(ny[YW-1:0]) * 32'(GRID_WIDTH) + 32'(nx[XW-1:0]));
    assign tap_is_drop = r_drop_on && (tap_addr == r_drop_addr);
    assign read_addr = AW'(32'(r_ry) * 32'(GRID_WIDTH) + 32'(r_rx));
    assign read_in   = (32'(r_rx) < 32'(GRID_WIDTH)) && (32'(r_ry) < 32'(GRID_HEIGHT));
    assign lvl_raddr = i_cmd.rd_pix ? read_addr : tap_addr;
    assign lvl_rd    = r_bank ? rd1 : rd0;

    assign dx_m = wrap(i_drop_x, GRID_WIDTH);
    assign dy_m = wrap(i_drop_y, GRID_HEIGHT);
    assign drop_ok = (40'(r_byte_total) < 40'(r_desired) * 40'(NCELL))
                  && ({1'b0, i_now_seconds} > 33'(r_last) + 33'(r_gap));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nxt[c]   = sat24(34'(r_lvl[c]) + 34'(r_nv[c]));
            nbyte[c] = led_clamp(nxt[c]);
            rbyte[c] = read_in ? led_clamp(lvl_rd[LVL_W*c +: LVL_W]) : 8'd0;
        end
        next_word = {nxt[2], nxt[1], nxt[0]};
    end

    // next frame goes to the other bank; the clearing pass hits bank 0
    assign we0 = i_cmd.clr || (i_cmd.wr && r_bank);
    assign we1 = i_cmd.wr && !r_bank;
    assign vwe = i_cmd.clr || i_cmd.wr;

    dwrg_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_lvl0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(pix_addr),
        .i_wdata(i_cmd.clr ? '0 : next_word), .i_raddr(lvl_raddr), .o_rdata(rd0)
    );
    dwrg_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_lvl1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(pix_addr),
        .i_wdata(next_word), .i_raddr(lvl_raddr), .o_rdata(rd1)
    );
    dwrg_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_vel (
        .i_clk(i_clk), .i_we(vwe), .i_waddr(pix_addr),
        .i_wdata(i_cmd.clr ? '0 : {r_nv[2], r_nv[1], r_nv[0]}),
        .i_raddr(pix_addr), .o_rdata(vel_rd)
    );

    t_lvl vel [3];
    assign vel[0] = vel_rd[LVL_W-1:0];
    assign vel[1] = vel_rd[2*LVL_W-1:LVL_W];
    assign vel[2] = vel_rd[3*LVL_W-1:2*LVL_W];

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_m_v <= i_cmd.tap_issue && tap_in && (i_cmd.tap != TAP_CENTER);
        r_m_c <= i_cmd.tap_issue && (i_cmd.tap == TAP_CENTER);
        r_m_d <= tap_is_drop;
        r_m_w <= tap_weight(i_cmd.tap);
        r_pv  <= r_m_v;
        for (int c = 0; c < 3; c++) begin
            t_lvl chl;
            chl = r_m_d ? DROP_RAW : lvl_rd[LVL_W*c +: LVL_W];
            r_prod[c] <= 41'(chl) * 41'($signed({1'b0, r_m_w}));
            if (r_m_c) r_lvl[c] <= chl;
            if (i_cmd.tap_issue && i_cmd.tap == '0) r_acc[c] <= '0;
            else if (r_pv) r_acc[c] <= r_acc[c] + 44'(r_prod[c]);
            if (i_cmd.calc1) begin
                r_diff[c]  <= 29'((r_acc[c] + 44'sd32768) >>> 16) - 29'(r_lvl[c]);
                r_dprod[c] <= 33'(vel[c]) * 33'($signed({1'b0, DAMP}));
            end
            if (i_cmd.calc2) begin
                r_aprod[c] <= 46'(r_diff[c]) * 46'($signed({1'b0, SPRING[c]}));
            end
            if (i_cmd.calc3) begin
                r_nv[c] <= sat24(34'(vel[c])
                        + 34'(30'((r_aprod[c] + 46'sd32768) >>> 16))
                        - 34'(17'((r_dprod[c] + 33'sd32768) >>> 16)));
            end
        end
        if (i_cmd.accept) begin
            r_rx        <= i_read_x;
            r_ry        <= i_read_y;
            r_drop_addr <= AW'(32'(dy_m) * 32'(GRID_WIDTH) + 32'(dx_m));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desired    <= 8'd0;
            r_gap        <= 8'd2;
            r_last       <= '0;
            r_byte_total <= '0;
            r_tot        <= '0;
            r_bank       <= 1'b0;
            r_drop_on    <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DESIRED: r_desired <= i_cfg_data;
                    CFG_GAP:     r_gap     <= i_cfg_data;
                    default:     r_gap     <= r_gap;
                endcase
            end
            if (i_cmd.accept && !i_action) begin
                r_tot <= '0;
                if (drop_ok) begin
                    r_drop_on <= 1'b1;
                    r_last    <= i_now_seconds;
                end
            end
            if (i_cmd.wr) begin
                r_tot <= r_tot + TOT_W'(nbyte[0]) + TOT_W'(nbyte[1]) + TOT_W'(nbyte[2]);
            end
            if (i_cmd.fin) begin
                r_bank       <= ~r_bank;
                r_byte_total <= r_tot;
                r_drop_on    <= 1'b0;
            end
            if (i_cmd.fin || i_cmd.out_rd) o_valid <= 1'b1;
            else if (i_ready)              o_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_red_byte    <= 8'd0;
            o_green_byte  <= 8'd0;
            o_blue_byte   <= 8'd0;
            o_level_total <= (32'(r_tot) > 32'hFFFF) ? 16'hFFFF : 16'(r_tot);
            o_drop_made   <= r_drop_on;
        end else if (i_cmd.out_rd) begin
            o_red_byte    <= rbyte[0];
            o_green_byte  <= rbyte[1];
            o_blue_byte   <= rbyte[2];
            o_level_total <= (32'(r_byte_total) > 32'hFFFF) ? 16'hFFFF : 16'(r_byte_total);
            o_drop_made   <= 1'b0;
        end
    end

    assign o_st.out_free = !o_valid || i_ready;

    a_no_fin_drop_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> !r_drop_on)
        else $error("drop flag survived frame end");
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_bank != $past(r_bank)))
        else $error("bank did not swap");
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we0 && we1))
        else $error("both level banks written");
endmodule
`default_nettype wire
